// ===== hw/rtl/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types for the reversible deque: operation codes, controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rde_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_TOGGLE     = 3'd4
  } op_kind_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_HOLD
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic apply;     // apply the accepted operation to the store
    logic rd_issue;  // issue one scan read
    logic load_out;  // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;  // deque holds no element
    logic rd_last;   // current scan read is the final element
  } dp_stat_t;

endpackage

// ===== hw/rtl/rde_ctrl.sv =====
// ----------------------------------------------------------------------------
// rde_ctrl
// Sequencer for the deque: accepts one operation, steps the datapath through
// the extremes scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module rde_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  rde_pkg::dp_stat_t stat,
  output rde_pkg::dp_cmd_t  cmd
);
  import rde_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        m_tvalid_next;

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.cnt_zero) state_next = ST_HOLD;
        else if (stat.rd_last) state_next = ST_LAST;
      end
      ST_LAST: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    s_tready     = 1'b0;
    cmd.apply    = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.apply = s_tvalid;
      end
      ST_SCAN: begin
        cmd.rd_issue = !stat.cnt_zero;
      end
      ST_LAST: begin
      end
      ST_HOLD: begin
        cmd.load_out = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // result register valid: set on load, cleared once the transaction completes
  always_comb begin
    if (cmd.load_out) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

endmodule

// ===== hw/rtl/rde_datapath.sv =====
// ----------------------------------------------------------------------------
// rde_datapath
// Ring store with head pointer, count and reverse flag, a sequential scan
// for maximum and minimum, and the result register.
// ----------------------------------------------------------------------------
module rde_datapath #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rde_pkg::dp_cmd_t             cmd,
  output rde_pkg::dp_stat_t            stat,
  input  logic [2:0]                   kind,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  output logic signed [DATA_WIDTH-1:0] front_value,
  output logic signed [DATA_WIDTH-1:0] back_value,
  output logic [CW-1:0]                entry_count,
  output logic signed [DATA_WIDTH-1:0] largest_value,
  output logic signed [DATA_WIDTH-1:0] smallest_value,
  output logic                         is_reversed,
  output logic                         pop_on_empty,
  output logic                         push_dropped
);
  import rde_pkg::*;

  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  // pointer state
  logic [AW-1:0] first_slot;
  logic [AW-1:0] first_slot_next;
  logic [CW-1:0] stored_count;
  logic [CW-1:0] stored_count_next;
  logic          reversed_flag;
  logic          reversed_flag_next;
  logic          pop_err;
  logic          pop_err_next;
  logic          push_err;
  logic          push_err_next;

  // write side
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic          push_req;
  logic          pop_req;
  logic          at_head;
  logic          full;
  logic          empty;

  // scan side
  logic [AW-1:0]                rd_idx;
  logic [AW:0]                  rd_sum;
  logic [AW-1:0]                rd_addr;
  logic                         rd_valid;
  logic                         rd_first;
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic signed [DATA_WIDTH-1:0] head_v;
  logic signed [DATA_WIDTH-1:0] tail_v;
  logic signed [DATA_WIDTH-1:0] hi;
  logic signed [DATA_WIDTH-1:0] lo;

  // slot arithmetic modulo the depth
  assign full      = stored_count == DEPTH_C;
  assign empty     = stored_count == '0;
  assign tail_sum  = {1'b0, first_slot} + (AW + 1)'(stored_count);
  assign tail_slot = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
  assign head_dec  = (first_slot == '0) ? LAST_SLOT : first_slot - 1'b1;
  assign head_inc  = (first_slot == LAST_SLOT) ? '0 : first_slot + 1'b1;

  // decode the operation; reversal swaps which physical end is touched
  always_comb begin
    push_req           = 1'b0;
    pop_req            = 1'b0;
    at_head            = 1'b0;
    reversed_flag_next = reversed_flag;
    case (op_kind_t'(kind))
      KIND_PUSH_BACK: begin
        push_req = 1'b1;
        at_head  = reversed_flag;
      end
      KIND_PUSH_FRONT: begin
        push_req = 1'b1;
        at_head  = !reversed_flag;
      end
      KIND_POP_BACK: begin
        pop_req = 1'b1;
        at_head = reversed_flag;
      end
      KIND_POP_FRONT: begin
        pop_req = 1'b1;
        at_head = !reversed_flag;
      end
      KIND_TOGGLE: begin
        reversed_flag_next = !reversed_flag;
      end
      default: begin
      end
    endcase
  end

  // pointer, count and error update
  always_comb begin
    first_slot_next   = first_slot;
    stored_count_next = stored_count;
    wr_en             = 1'b0;
    wr_addr           = tail_slot;
    pop_err_next      = 1'b0;
    push_err_next     = 1'b0;
    if (push_req) begin
      if (full) begin
        push_err_next = 1'b1;
      end else begin
        wr_en             = 1'b1;
        stored_count_next = stored_count + 1'b1;
        if (at_head) begin
          first_slot_next = head_dec;
          wr_addr         = head_dec;
        end
      end
    end
    if (pop_req) begin
      if (empty) begin
        pop_err_next = 1'b1;
      end else begin
        stored_count_next = stored_count - 1'b1;
        if (at_head) first_slot_next = head_inc;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_slot    <= '0;
      stored_count  <= '0;
      reversed_flag <= 1'b0;
      rd_valid      <= 1'b0;
      rd_first      <= 1'b0;
    end else begin
      if (cmd.apply) begin
        first_slot    <= first_slot_next;
        stored_count  <= stored_count_next;
        reversed_flag <= reversed_flag_next;
      end
      rd_valid <= cmd.rd_issue;
      rd_first <= cmd.rd_issue && (rd_idx == '0);
    end
  end

  // error flags of the current operation
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      pop_err  <= pop_err_next;
      push_err <= push_err_next;
    end
  end

  // ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.apply && wr_en) mem[wr_addr] <= push_value;
    if (cmd.rd_issue) rd_data <= mem[rd_addr];
  end

  // scan address walks from the head
  assign rd_sum  = {1'b0, first_slot} + {1'b0, rd_idx};
  assign rd_addr = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : AW'(rd_sum);

  always_ff @(posedge clk) begin
    if (cmd.apply) rd_idx <= '0;
    else if (cmd.rd_issue) rd_idx <= rd_idx + 1'b1;
  end

  assign stat.cnt_zero = empty;
  assign stat.rd_last  = CW'(rd_idx) == (stored_count - 1'b1);

  // running extremes; first element seeds head, max and min
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      tail_v <= rd_data;
      if (rd_first) begin
        head_v <= rd_data;
        hi     <= rd_data;
        lo     <= rd_data;
      end else begin
        if (rd_data > hi) hi <= rd_data;
        if (rd_data < lo) lo <= rd_data;
      end
    end
  end

  // result register, zeros when empty
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entry_count  <= stored_count;
      is_reversed  <= reversed_flag;
      pop_on_empty <= pop_err;
      push_dropped <= push_err;
      if (empty) begin
        front_value    <= '0;
        back_value     <= '0;
        largest_value  <= '0;
        smallest_value <= '0;
      end else begin
        front_value    <= reversed_flag ? tail_v : head_v;
        back_value     <= reversed_flag ? head_v : tail_v;
        largest_value  <= hi;
        smallest_value <= lo;
      end
    end
  end

endmodule

// ===== hw/rtl/reversible_deque_with_extremes_top.sv =====
// ----------------------------------------------------------------------------
// reversible_deque_with_extremes_top
// Bounded double-ended queue with reverse flag, reporting front, back, count,
// maximum and minimum after every operation.
// ----------------------------------------------------------------------------
// Operation flow: the accepted operation updates the store, the scan then reads
// every stored element once per cycle through its single read port, and the
// result register is loaded. A new operation is accepted only once the
// previous result has been loaded into the result register.
// Reset: synchronous; empties the deque, clears the reverse flag and the
// output valid. Store contents are not cleared.
// ----------------------------------------------------------------------------
module reversible_deque_with_extremes_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int IN_W     = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS = 4 * DATA_WIDTH + CW + 3,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // push_value
  input  logic [2:0]       s_tuser,   // kind
  output logic             m_tvalid,
  input  logic             m_tready,
  // front_value, back_value, entry_count, largest_value, smallest_value,
  // is_reversed, pop_on_empty, push_dropped
  output logic [OUT_W-1:0] m_tdata
);
  import rde_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [DATA_WIDTH-1:0] front_value;
  logic signed [DATA_WIDTH-1:0] back_value;
  logic [CW-1:0]                entry_count;
  logic signed [DATA_WIDTH-1:0] largest_value;
  logic signed [DATA_WIDTH-1:0] smallest_value;
  logic                         is_reversed;
  logic                         pop_on_empty;
  logic                         push_dropped;

  // sequencer
  rde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, scan and result register
  rde_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (s_tuser),
    .push_value     (s_tdata[DATA_WIDTH-1:0]),
    .front_value    (front_value),
    .back_value     (back_value),
    .entry_count    (entry_count),
    .largest_value  (largest_value),
    .smallest_value (smallest_value),
    .is_reversed    (is_reversed),
    .pop_on_empty   (pop_on_empty),
    .push_dropped   (push_dropped)
  );

  // pack the result fields, lowest field first, zero padding on top
  always_comb begin
    m_tdata               = '0;
    m_tdata[OUT_BITS-1:0] = {push_dropped, pop_on_empty, is_reversed, smallest_value,
                             largest_value, entry_count, back_value, front_value};
  end

endmodule

// ===== hw/rtl/rde_checker.sv =====
// ----------------------------------------------------------------------------
// rde_checker
// Port-level checks for the reversible deque, bound to the top level.
// ----------------------------------------------------------------------------
module rde_checker #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int OUT_BITS = 4 * DATA_WIDTH + CW + 3,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int CNT_LO   = 2 * DATA_WIDTH,
  localparam int HI_LO    = CNT_LO + CW,
  localparam int LO_LO    = HI_LO + DATA_WIDTH,
  localparam int FLAG_LO  = LO_LO + DATA_WIDTH
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [CW-1:0]         count_f;
  logic [DATA_WIDTH-1:0] front_f;
  logic [DATA_WIDTH-1:0] back_f;
  logic [DATA_WIDTH-1:0] hi_f;
  logic [DATA_WIDTH-1:0] lo_f;
  logic                  pop_f;
  logic                  push_f;

  // field views of the result
  assign front_f = m_tdata[DATA_WIDTH-1:0];
  assign back_f  = m_tdata[CNT_LO-1:DATA_WIDTH];
  assign count_f = m_tdata[HI_LO-1:CNT_LO];
  assign hi_f    = m_tdata[LO_LO-1:HI_LO];
  assign lo_f    = m_tdata[FLAG_LO-1:LO_LO];
  assign pop_f   = m_tdata[FLAG_LO+1];
  assign push_f  = m_tdata[FLAG_LO+2];

  // one operation in flight: input closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // empty deque reports zero values
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && count_f == '0) |->
      (front_f == '0 && back_f == '0 && hi_f == '0 && lo_f == '0))
    else $error("empty deque reports a non-zero value");

  // a dropped push only happens when full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && push_f) |-> (count_f == CW'(DEPTH) && !pop_f))
    else $error("push dropped while not full");

  // a failed pop only happens when empty
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && pop_f) |-> (count_f == '0 && !push_f))
    else $error("pop flagged while not empty");

endmodule

bind reversible_deque_with_extremes_top rde_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_rde_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/tb_reversible_deque_with_extremes_top.sv =====
// ----------------------------------------------------------------------------
// tb_reversible_deque_with_extremes_top
// Self-checking bench for the reversible deque. A directed opening exercises
// empty pops, extreme words, reversal and the unused operation codes. Random
// fill, drain and mixed phases follow, pushing the store to full and back to empty.
// A shadow deque predicts the status after every operation, and each output
// transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_reversible_deque_with_extremes_top;
  import rde_pkg::*;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int STATUS_W   = 4 * DATA_WIDTH + 7 + 3;
  localparam int NUM_OPS    = 600;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 80;

  // one operation as presented on the input stream
  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } deque_op_t;

  // status word, lowest field in the lowest bits
  typedef struct packed {
    logic               push_dropped;
    logic               pop_on_empty;
    logic               is_reversed;
    logic signed [31:0] smallest_value;
    logic signed [31:0] largest_value;
    logic [6:0]         entry_count;
    logic signed [31:0] back_value;
    logic signed [31:0] front_value;
  } deque_status_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // push_value
  logic [2:0]   s_tuser = '0;   // kind
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // front_value, back_value, entry_count, largest_value, smallest_value,
  // is_reversed, pop_on_empty, push_dropped
  logic [143:0] m_tdata;

  // stimulus, shadow contents and predicted status
  deque_op_t          op_queue[$];
  logic signed [31:0] shadow_q[$];
  logic               shadow_reversed = 1'b0;
  deque_status_t      status_expect_q[$];

  int unsigned  fail_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_wait = 0;
  int unsigned  recv_wait = 0;
  int unsigned  total_ops = 0;
  int unsigned  recv_count = 0;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;
  bit           send_busy;
  bit           recv_ready;
  deque_op_t    next_op;

  reversible_deque_with_extremes_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock and reset
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // gap before the next transaction, with occasional runs of no gaps at all
  function automatic int unsigned draw_gap(inout bit quiet);
    if ($urandom_range(0, 29) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // mostly random words, with the signed extremes mixed in
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_op(logic [2:0] kind, logic signed [31:0] value);
    deque_op_t op;
    op.kind  = kind;
    op.value = value;
    op_queue.insert(op_queue.size(), op);
  endfunction

  // apply one operation to the shadow deque and work out the status
  function automatic deque_status_t predict_status(deque_op_t op);
    deque_status_t      st;
    logic signed [31:0] flipped[$];
    st = '0;
    case (op.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (shadow_q.size() >= DEPTH) begin
          st.push_dropped = 1'b1;
        end else if (op.kind == KIND_PUSH_BACK) begin
          shadow_q.insert(shadow_q.size(), op.value);
        end else begin
          shadow_q.insert(0, op.value);
        end
      end
      KIND_POP_BACK, KIND_POP_FRONT: begin
        if (shadow_q.size() == 0) begin
          st.pop_on_empty = 1'b1;
        end else if (op.kind == KIND_POP_BACK) begin
          shadow_q.delete(shadow_q.size() - 1);
        end else begin
          shadow_q.delete(0);
        end
      end
      KIND_TOGGLE: begin
        foreach (shadow_q[i]) flipped.insert(0, shadow_q[i]);
        shadow_q = flipped;
        shadow_reversed = ~shadow_reversed;
      end
      default: ;
    endcase
    st.is_reversed = shadow_reversed;
    st.entry_count = 7'(shadow_q.size());
    if (shadow_q.size() > 0) begin
      st.front_value    = shadow_q[0];
      st.back_value     = shadow_q[$];
      st.largest_value  = shadow_q[0];
      st.smallest_value = shadow_q[0];
      foreach (shadow_q[i]) begin
        if (shadow_q[i] > st.largest_value) st.largest_value = shadow_q[i];
        if (shadow_q[i] < st.smallest_value) st.smallest_value = shadow_q[i];
      end
    end
    return st;
  endfunction

  // directed opening, then random fill, drain and mixed phases
  task automatic build_stimulus();
    int unsigned phase;
    int unsigned len;
    int unsigned roll;
    int unsigned push_pct;
    bit          at_back;
    // empty pops, reversal and extreme words
    add_op(KIND_POP_BACK, 32'h0);
    add_op(KIND_POP_FRONT, 32'hFFFF_FFFF);
    add_op(KIND_TOGGLE, 32'h0);
    add_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    add_op(KIND_PUSH_FRONT, 32'h8000_0000);
    add_op(KIND_PUSH_BACK, 32'h0);
    add_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
    add_op(KIND_TOGGLE, 32'h0);
    add_op(KIND_PUSH_BACK, 32'h0000_0001);
    add_op(KIND_PUSH_FRONT, $urandom);
    // unused operation codes change nothing
    add_op(3'd5, $urandom);
    add_op(3'd6, $urandom);
    add_op(3'd7, $urandom);
    add_op(KIND_POP_BACK, 32'h0);
    add_op(KIND_POP_FRONT, 32'h0);
    add_op(KIND_TOGGLE, 32'h0);
    repeat (5) begin
      add_op(KIND_POP_BACK, 32'h0);
      add_op(KIND_POP_FRONT, 32'h0);
    end
    add_op(KIND_TOGGLE, 32'h0);

    while (op_queue.size() < NUM_OPS) begin
      phase = $urandom_range(0, 3);
      len   = $urandom_range(60, 120);
      // fill phases dominate so that the full case is reached often
      push_pct = (phase <= 1) ? 90 : (phase == 2) ? 12 : 50;
      repeat (len) begin
        if (op_queue.size() >= NUM_OPS) break;
        roll    = $urandom_range(0, 99);
        at_back = $urandom_range(0, 1);
        if (roll < 2) begin
          add_op(3'($urandom_range(5, 7)), $urandom);
        end else if (roll < 6) begin
          add_op(KIND_TOGGLE, $urandom);
        end else if ($urandom_range(0, 99) < push_pct) begin
          add_op(at_back ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_word());
        end else begin
          add_op(at_back ? KIND_POP_BACK : KIND_POP_FRONT, $urandom);
        end
      end
    end
  endtask

  // input driver: predicts on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = draw_gap(send_quiet);
    end else begin
      send_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        status_expect_q.insert(status_expect_q.size(), predict_status(next_op));
        send_busy = 1'b0;
        send_wait = draw_gap(send_quiet);
      end
      if (!send_busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (op_queue.size() > 0) begin
          next_op = op_queue[0];
          op_queue.delete(0);
          send_busy = 1'b1;
          s_tdata  <= next_op.value;
          s_tuser  <= next_op.kind;
        end
      end
      s_tvalid <= send_busy;
    end
  end

  // output monitor: random back-pressure and comparison
  always @(posedge clk) begin
    deque_status_t got;
    deque_status_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = draw_gap(recv_quiet);
    end else begin
      recv_ready = m_tready;
      if (m_tvalid && m_tready) begin
        recv_count++;
        got = m_tdata[STATUS_W-1:0];
        if (status_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected status transaction: %h", m_tdata);
        end else begin
          want = status_expect_q[0];
          status_expect_q.delete(0);
          if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
              got.entry_count !== want.entry_count ||
              got.largest_value !== want.largest_value ||
              got.smallest_value !== want.smallest_value ||
              got.is_reversed !== want.is_reversed ||
              got.pop_on_empty !== want.pop_on_empty ||
              got.push_dropped !== want.push_dropped) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("status mismatch");
              $display("  expected: front %0d back %0d count %0d max %0d min %0d",
                       want.front_value, want.back_value, want.entry_count,
                       want.largest_value, want.smallest_value);
              $display("            rev %b pop_err %b push_err %b",
                       want.is_reversed, want.pop_on_empty, want.push_dropped);
              $display("  actual:   front %0d back %0d count %0d max %0d min %0d",
                       got.front_value, got.back_value, got.entry_count,
                       got.largest_value, got.smallest_value);
              $display("            rev %b pop_err %b push_err %b",
                       got.is_reversed, got.pop_on_empty, got.push_dropped);
            end
          end
        end
        recv_ready = 1'b0;
        recv_wait  = draw_gap(recv_quiet);
      end
      if (!recv_ready) begin
        if (recv_wait > 0) recv_wait--;
        else recv_ready = 1'b1;
      end
      m_tready <= recv_ready;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    build_stimulus();
    total_ops = op_queue.size();
    @(negedge rst);
    while (recv_count < total_ops)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && status_expect_q.size() == 0 && recv_count == total_ops) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
